// ===== rtl/twiw_pkg.sv =====
// Shared types and constants for the twirl image warp core.
// No dependencies; the core and twiw_cordic refer to it by scoped names.
`default_nettype none

package twiw_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE    = 2'd2;

  // Register reset values
  localparam logic [8:0]         RESET_WIDTH  = 9'd256;
  localparam logic [8:0]         RESET_HEIGHT = 9'd256;
  localparam logic signed [15:0] RESET_ANGLE  = 16'sd2560;

  // Frame store size defaults
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Angle to phase: round(2^32 / (512*pi)), turns with 32 fraction bits per Q8 radian
  localparam logic [31:0] RAD_Q8_TO_TURN = 32'd2670177;

  // CORDIC sin/cos unit
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CX_W = 18;
  localparam logic signed [CX_W-1:0] CORDIC_START = 18'sd39797;
  localparam logic [31:0] CORDIC_ATAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic       cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } twiw_src_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } twiw_res_t;

  // What travels with every word down the pipeline
  typedef struct packed {
    logic        cmd;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [23:0] rgb;
  } twiw_tag_t;

endpackage

`default_nettype wire

// ===== rtl/twirl_image_warp_core.sv =====
// Twirl image warp: RGB frame store with a twirled read-out, fully pipelined.
// Depends on twiw_pkg, twiw_ram, twiw_div, twiw_sqrt and twiw_cordic.
//
// Usage:
//   src channel (src_valid / src_stall / src_word): one word per command. A write
//   word (cmd = write) stores its RGB value at (pos_x, pos_y) of the frame store and
//   gives no result; a word outside the store is dropped. A read word (cmd = read)
//   gives one res word: the stored pixel that the twirl maps to (pos_x, pos_y).
//   res channel (res_valid / res_stall / res_word): results in command order.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//   always ready; write only while no command is in flight.
// Throughput: one word per clock while no result is stalled. Every word walks the same pipeline, so writes
//   and reads reach the frame store in order.
// Depth: the one-bit-per-stage divider over NW = 2*DXW + 31 numerator bits and the
//   square root over RW = ceil(NW/2) root bits dominate the pipeline depth.
// Stall: a stalled result freezes the whole pipeline, and src_stall rises in the
//   same cycle; nothing is dropped or repeated.
// Reset: clears all valid bits and loads the register defaults (256 x 256, angle
//   2560). The frame store is not cleared; read only pixels that were written.
`default_nettype none

module twirl_image_warp_core #(
  parameter int unsigned MAX_WIDTH  = twiw_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = twiw_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               src_valid,
  output      logic                               src_stall,
  input  wire twiw_pkg::twiw_src_t                src_word,
  output      logic                               res_valid,
  input  wire logic                               res_stall,
  output      twiw_pkg::twiw_res_t                res_word,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [twiw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [twiw_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DW     = $clog2(DIM + 1);          // clamped width/height
  localparam int unsigned CFW    = (DW > 9) ? DW : 9;
  localparam int unsigned DXW    = (DW + 1 > 9) ? DW + 1 : 9; // signed center offset
  localparam int unsigned D2W    = 2 * DXW - 1;               // dx^2 + dy^2
  localparam int unsigned NW     = D2W + 32;                  // scaled numerator
  localparam int unsigned DDW    = 2 * DW + 1;                // w^2 + h^2
  localparam int unsigned RW     = (NW + 1) / 2;              // radius ratio, Q16
  localparam int unsigned VW     = 2 * RW;
  localparam int unsigned PRW    = 16 + RW;                   // |angle| * ratio
  localparam int unsigned TW     = RW + 2;                    // signed angle
  localparam int unsigned XW     = twiw_pkg::CX_W;
  localparam int unsigned PW     = DXW + XW;                  // offset x cos/sin
  localparam int unsigned VSW    = PW + 2;
  localparam int unsigned OFW    = VSW - 16;
  localparam int unsigned SXW    = OFW + 1;
  localparam int unsigned XAW    = $clog2(MAX_WIDTH);
  localparam int unsigned YAW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned TAG_W  = $bits(twiw_pkg::twiw_tag_t);
  localparam int unsigned SIDE_W = TAG_W + 2 * DXW;

  // ---------------------------------------------------------------------------
  // Configuration: store sizes already clamped to the frame store
  // ---------------------------------------------------------------------------
  logic [DW-1:0]         w_eff;
  logic [DW-1:0]         h_eff;
  logic signed [15:0]    ang;
  logic [DDW-1:0]        diag2;
  logic [15:0]           abs_ang;

  function automatic logic [DW-1:0] clamp_dim(input logic [8:0] v, input int unsigned hi);
    logic [CFW-1:0] ve;
    ve = CFW'(v);
    if (ve == '0) begin
      return DW'(1);
    end
    if (ve > CFW'(hi)) begin
      return DW'(hi);
    end
    return DW'(ve);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= clamp_dim(twiw_pkg::RESET_WIDTH, MAX_WIDTH);
      h_eff <= clamp_dim(twiw_pkg::RESET_HEIGHT, MAX_HEIGHT);
      ang   <= twiw_pkg::RESET_ANGLE;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        twiw_pkg::CFG_IMAGE_WIDTH:  w_eff <= clamp_dim(cfg_data[8:0], MAX_WIDTH);
        twiw_pkg::CFG_IMAGE_HEIGHT: h_eff <= clamp_dim(cfg_data[8:0], MAX_HEIGHT);
        twiw_pkg::CFG_MAX_ANGLE:    ang   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Squared diagonal, settled long before any word reaches the divider
  always_ff @(posedge clk) begin
    diag2 <= DDW'(w_eff) * DDW'(w_eff) + DDW'(h_eff) * DDW'(h_eff);
  end

  assign abs_ang = ang[15] ? 16'(-ang) : 16'(ang);

  // ---------------------------------------------------------------------------
  // Global advance: freeze everything while a result waits on a stalled receiver
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv       = !(res_valid && res_stall);
  assign src_stall = !adv;

  // ---------------------------------------------------------------------------
  // S1: center offsets; S2: squared radius scaled by 2^32
  // ---------------------------------------------------------------------------
  logic                     s1_valid, s2_valid;
  twiw_pkg::twiw_tag_t      s1_tag;
  logic signed [DXW-1:0]    s1_dx, s1_dy;
  logic [NW-1:0]            s2_numer;
  logic [SIDE_W-1:0]        s2_side;
  logic signed [2*DXW-1:0]  sq_x, sq_y;

  assign sq_x = s1_dx * s1_dx;
  assign sq_y = s1_dy * s1_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= src_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag.cmd <= src_word.cmd;
      s1_tag.px  <= src_word.pos_x;
      s1_tag.py  <= src_word.pos_y;
      s1_tag.rgb <= {src_word.in_red, src_word.in_green, src_word.in_blue};
      s1_dx      <= signed'(DXW'(src_word.pos_x)) - signed'(DXW'(w_eff >> 1));
      s1_dy      <= signed'(DXW'(src_word.pos_y)) - signed'(DXW'(h_eff >> 1));
      s2_numer   <= {D2W'(sq_x + sq_y), 32'd0};
      s2_side    <= {s1_tag, s1_dx, s1_dy};
    end
  end

  // ---------------------------------------------------------------------------
  // Ratio of radius to diagonal: divide, then square root
  // ---------------------------------------------------------------------------
  logic              dv_valid, sq_valid;
  logic [SIDE_W-1:0] dv_side, sq_side;
  logic [NW-1:0]     dv_quot;
  logic [RW-1:0]     ratio;

  twiw_div #(
    .NW     (NW),
    .DDW    (DDW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s2_valid),
    .in_side   (s2_side),
    .numer     (s2_numer),
    .divisor   (diag2),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .quot      (dv_quot)
  );

  twiw_sqrt #(
    .RW     (RW),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (dv_valid),
    .in_side   (dv_side),
    .radicand  (VW'(dv_quot)),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .root      (ratio)
  );

  // ---------------------------------------------------------------------------
  // A1: |angle| * ratio; A2: round half away from zero, sign; A3: to phase turns
  // ---------------------------------------------------------------------------
  logic               a1_valid, a2_valid, a3_valid;
  logic [SIDE_W-1:0]  a1_side, a2_side, a3_side;
  logic [PRW-1:0]     a1_prod;
  logic signed [TW-1:0] a2_theta;
  logic [31:0]        a3_phase;
  logic [PRW:0]       a1_round;
  logic [RW:0]        a1_mag;
  logic [31:0]        theta32;

  assign a1_round = {1'b0, a1_prod} + (PRW+1)'(32768);
  assign a1_mag   = a1_round[PRW -: RW+1];
  assign theta32  = 32'(a2_theta);

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_valid <= 1'b0;
      a2_valid <= 1'b0;
      a3_valid <= 1'b0;
    end else if (adv) begin
      a1_valid <= sq_valid;
      a2_valid <= a1_valid;
      a3_valid <= a2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_prod  <= PRW'(abs_ang) * PRW'(ratio);
      a1_side  <= sq_side;
      a2_theta <= ang[15] ? -signed'(TW'(a1_mag)) : signed'(TW'(a1_mag));
      a2_side  <= a1_side;
      a3_phase <= theta32 * twiw_pkg::RAD_Q8_TO_TURN;
      a3_side  <= a2_side;
    end
  end

  // ---------------------------------------------------------------------------
  // Sine and cosine of the twirl angle
  // ---------------------------------------------------------------------------
  logic                 cr_valid;
  logic [SIDE_W-1:0]    cr_side;
  logic signed [XW-1:0] cr_cos, cr_sin;

  twiw_cordic #(
    .SIDE_W (SIDE_W)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (a3_valid),
    .in_side   (a3_side),
    .phase     (a3_phase),
    .out_valid (cr_valid),
    .out_side  (cr_side),
    .cos_q16   (cr_cos),
    .sin_q16   (cr_sin)
  );

  // ---------------------------------------------------------------------------
  // O1: rotate products; O2: displacement truncated toward zero;
  // O3: source position clamped (or write position checked); O4: store address
  // ---------------------------------------------------------------------------
  twiw_pkg::twiw_tag_t  cr_tag, o1_tag, o2_tag, o3_tag, o4_tag;
  logic signed [DXW-1:0] cr_dx, cr_dy, o1_dx, o1_dy;
  logic                 o1_valid, o2_valid, o3_valid, o4_valid;
  logic signed [PW-1:0] o1_xc, o1_ys, o1_xs, o1_yc;
  logic signed [VSW-1:0] vx, vy;
  logic [VSW-1:0]       vx_mag, vy_mag;
  logic [OFW-1:0]       tx, ty;
  logic signed [OFW-1:0] o2_ox, o2_oy;
  logic signed [SXW-1:0] sx, sy;
  logic signed [SXW-1:0] w_lim, h_lim;
  logic [XAW-1:0]       col_next, o3_col;
  logic [YAW-1:0]       row_next, o3_row;
  logic                 keep_next, o3_keep;
  logic [AW-1:0]        o4_addr;

  assign cr_tag = twiw_pkg::twiw_tag_t'(cr_side[SIDE_W-1 -: TAG_W]);
  assign cr_dx  = signed'(cr_side[2*DXW-1 -: DXW]);
  assign cr_dy  = signed'(cr_side[DXW-1:0]);

  always_comb begin
    vx     = VSW'(o1_xc) - VSW'(o1_ys) - (VSW'(o1_dx) <<< 16);
    vy     = VSW'(o1_xs) + VSW'(o1_yc) - (VSW'(o1_dy) <<< 16);
    vx_mag = vx[VSW-1] ? VSW'(-vx) : VSW'(vx);
    vy_mag = vy[VSW-1] ? VSW'(-vy) : VSW'(vy);
    tx     = vx_mag[VSW-1:16];
    ty     = vy_mag[VSW-1:16];
  end

  assign sx    = signed'(SXW'(o2_tag.px)) + SXW'(o2_ox);
  assign sy    = signed'(SXW'(o2_tag.py)) + SXW'(o2_oy);
  assign w_lim = signed'(SXW'(w_eff - DW'(1)));
  assign h_lim = signed'(SXW'(h_eff - DW'(1)));

  // Reads clamp into the active image; writes keep their own position
  always_comb begin
    if (o2_tag.cmd == twiw_pkg::CMD_READ) begin
      keep_next = 1'b1;
      priority if (sx < 0) begin
        col_next = '0;
      end else if (sx > w_lim) begin
        col_next = XAW'(w_lim);
      end else begin
        col_next = XAW'(sx);
      end
      priority if (sy < 0) begin
        row_next = '0;
      end else if (sy > h_lim) begin
        row_next = YAW'(h_lim);
      end else begin
        row_next = YAW'(sy);
      end
    end else begin
      keep_next = (32'(o2_tag.px) < MAX_WIDTH) && (32'(o2_tag.py) < MAX_HEIGHT);
      col_next  = XAW'(o2_tag.px);
      row_next  = YAW'(o2_tag.py);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_valid <= 1'b0;
      o2_valid <= 1'b0;
      o3_valid <= 1'b0;
      o4_valid <= 1'b0;
    end else if (adv) begin
      o1_valid <= cr_valid;
      o2_valid <= o1_valid;
      o3_valid <= o2_valid;
      o4_valid <= o3_valid && o3_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o1_xc   <= PW'(cr_dx) * PW'(cr_cos);
      o1_ys   <= PW'(cr_dy) * PW'(cr_sin);
      o1_xs   <= PW'(cr_dx) * PW'(cr_sin);
      o1_yc   <= PW'(cr_dy) * PW'(cr_cos);
      o1_dx   <= cr_dx;
      o1_dy   <= cr_dy;
      o1_tag  <= cr_tag;
      o2_ox   <= vx[VSW-1] ? -signed'(tx) : signed'(tx);
      o2_oy   <= vy[VSW-1] ? -signed'(ty) : signed'(ty);
      o2_tag  <= o1_tag;
      o3_col  <= col_next;
      o3_row  <= row_next;
      o3_keep <= keep_next;
      o3_tag  <= o2_tag;
      o4_addr <= AW'(o3_row) * AW'(MAX_WIDTH) + AW'(o3_col);
      o4_tag  <= o3_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame store access and result register (the RAM read register)
  // ---------------------------------------------------------------------------
  logic        ram_we, ram_re;
  logic [23:0] ram_rdata;

  assign ram_we = adv && o4_valid && (o4_tag.cmd == twiw_pkg::CMD_WRITE);
  assign ram_re = adv && o4_valid && (o4_tag.cmd == twiw_pkg::CMD_READ);

  twiw_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (o4_addr),
    .wdata (o4_tag.rgb),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= o4_valid && (o4_tag.cmd == twiw_pkg::CMD_READ);
    end
  end

  assign res_word = twiw_pkg::twiw_res_t'(ram_rdata);

endmodule

`default_nettype wire

// ===== rtl/twiw_ram.sv =====
// Generic single-address RAM with registered read data.
// No dependencies.
`default_nettype none

module twiw_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/twiw_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing outside this file.
`default_nettype none

module twiw_div #(
  parameter int unsigned NW     = 51,
  parameter int unsigned DDW    = 19,
  parameter int unsigned SIDE_W = 61
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SIDE_W-1:0] in_side,
  input  wire logic [NW-1:0]     numer,
  input  wire logic [DDW-1:0]    divisor,
  output      logic              out_valid,
  output      logic [SIDE_W-1:0] out_side,
  output      logic [NW-1:0]     quot
);

  logic [NW-1:0]     vld;
  logic [DDW-1:0]    rem  [NW];
  logic [NW-1:0]     nq   [NW];
  logic [SIDE_W-1:0] side [NW];

  // Shift in one numerator bit, subtract when it fits, shift the quotient bit in
  function automatic logic [DDW+NW-1:0] div_step(input logic [DDW-1:0] r,
                                                 input logic [NW-1:0] n,
                                                 input logic [DDW-1:0] d);
    logic [DDW:0] trial;
    logic [DDW:0] diff;
    logic         ge;
    trial = {r, n[NW-1]};
    diff  = trial - {1'b0, d};
    ge    = (trial >= {1'b0, d});
    return {(ge ? diff[DDW-1:0] : trial[DDW-1:0]), n[NW-2:0], ge};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {rem[0], nq[0]} <= div_step('0, numer, divisor);
      side[0] <= in_side;
      for (int i = 1; i < NW; i++) begin
        {rem[i], nq[i]} <= div_step(rem[i-1], nq[i-1], divisor);
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign out_side  = side[NW-1];
  assign quot      = nq[NW-1];

endmodule

`default_nettype wire

// ===== rtl/twiw_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on nothing outside this file.
`default_nettype none

module twiw_sqrt #(
  parameter int unsigned RW     = 26,
  parameter int unsigned SIDE_W = 61
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SIDE_W-1:0] in_side,
  input  wire logic [2*RW-1:0]   radicand,
  output      logic              out_valid,
  output      logic [SIDE_W-1:0] out_side,
  output      logic [RW-1:0]     root
);

  localparam int unsigned VW  = 2 * RW;
  localparam int unsigned RMW = RW + 2;

  logic [RW-1:0]     vld;
  logic [RMW-1:0]    rem  [RW];
  logic [RW-1:0]     rt   [RW];
  logic [VW-1:0]     v    [RW];
  logic [SIDE_W-1:0] side [RW];

  // Bring down two radicand bits, try root*4+1, keep the result bit
  function automatic logic [RMW+RW+VW-1:0] sqrt_step(input logic [RMW-1:0] r,
                                                     input logic [RW-1:0] q,
                                                     input logic [VW-1:0] x);
    logic [RMW+1:0] cand;
    logic [RMW+1:0] trial;
    logic           ge;
    cand  = {r, x[VW-1 -: 2]};
    trial = (RMW+2)'({q, 2'b01});
    ge    = (cand >= trial);
    return {(ge ? RMW'(cand - trial) : RMW'(cand)), q[RW-2:0], ge, x[VW-3:0], 2'b00};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {rem[0], rt[0], v[0]} <= sqrt_step('0, '0, radicand);
      side[0] <= in_side;
      for (int i = 1; i < RW; i++) begin
        {rem[i], rt[i], v[i]} <= sqrt_step(rem[i-1], rt[i-1], v[i-1]);
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_side  = side[RW-1];
  assign root      = rt[RW-1];

endmodule

`default_nettype wire

// ===== rtl/twiw_cordic.sv =====
// Pipelined CORDIC sine/cosine from a 32-bit phase in turns, with sideband.
// Depends on twiw_pkg (arctangent table, start value, widths).
`default_nettype none

module twiw_cordic #(
  parameter int unsigned SIDE_W = 61
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic [SIDE_W-1:0]                   in_side,
  input  wire logic [31:0]                         phase,
  output      logic                                out_valid,
  output      logic [SIDE_W-1:0]                   out_side,
  output      logic signed [twiw_pkg::CX_W-1:0]    cos_q16,
  output      logic signed [twiw_pkg::CX_W-1:0]    sin_q16
);

  localparam int unsigned N  = twiw_pkg::CORDIC_STEPS;
  localparam int unsigned XW = twiw_pkg::CX_W;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  logic [N-1:0]          vld;
  logic signed [XW-1:0]  x    [N];
  logic signed [XW-1:0]  y    [N];
  logic signed [31:0]    z    [N];
  logic [1:0]            quad [N];
  logic [SIDE_W-1:0]     side [N];

  // One micro-rotation toward z = 0 with floor shifts
  function automatic logic [2*XW+31:0] rot_step(input logic signed [XW-1:0] xi,
                                                input logic signed [XW-1:0] yi,
                                                input logic signed [31:0] zi,
                                                input int k);
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [31:0]   a;
    xs = xi >>> k;
    ys = yi >>> k;
    a  = signed'(twiw_pkg::CORDIC_ATAN[k[3:0]]);
    if (!zi[31]) begin
      return {xi - ys, yi + xs, zi - a};
    end
    return {xi + ys, yi - xs, zi + a};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {x[0], y[0], z[0]} <= rot_step(twiw_pkg::CORDIC_START, '0,
                                     signed'({2'b00, phase[29:0]}), 0);
      quad[0] <= phase[31:30];
      side[0] <= in_side;
      for (int i = 1; i < N; i++) begin
        {x[i], y[i], z[i]} <= rot_step(x[i-1], y[i-1], z[i-1], i);
        quad[i] <= quad[i-1];
        side[i] <= side[i-1];
      end
    end
  end

  // Fold the quadrant back in
  always_comb begin
    unique case (quad_t'(quad[N-1]))
      QUAD_I: begin
        cos_q16 = x[N-1];
        sin_q16 = y[N-1];
      end
      QUAD_II: begin
        cos_q16 = -y[N-1];
        sin_q16 = x[N-1];
      end
      QUAD_III: begin
        cos_q16 = -x[N-1];
        sin_q16 = -y[N-1];
      end
      QUAD_IV: begin
        cos_q16 = y[N-1];
        sin_q16 = -x[N-1];
      end
      default: begin
        cos_q16 = x[N-1];
        sin_q16 = y[N-1];
      end
    endcase
  end

  assign out_valid = vld[N-1];
  assign out_side  = side[N-1];

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for twirl_image_warp_core: fills the frame store, reads twirled pixels.
// Depends on twiw_pkg and the core; keeps its own copy of the store and the twirl math.
// Runs phases of register settings, each started only once the pipeline has drained.
module tb_top;

  localparam int FRAME_W = 256;
  localparam int FRAME_H = 256;
  localparam int DRAIN_CYCLES = 150;   // a little over the pipeline depth
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 180;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  twiw_pkg::twiw_src_t src_word = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  twiw_pkg::twiw_res_t res_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [twiw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [twiw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  twirl_image_warp_core dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_word(src_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Our own copy of the registers and the frame store
  logic [8:0] img_w = twiw_pkg::RESET_WIDTH;
  logic [8:0] img_h = twiw_pkg::RESET_HEIGHT;
  logic signed [15:0] twist = twiw_pkg::RESET_ANGLE;
  logic [23:0] frame_pix [FRAME_W*FRAME_H];
  bit pix_written [FRAME_W*FRAME_H];

  twiw_pkg::twiw_src_t pending_words [$];
  twiw_pkg::twiw_res_t expected_pixels [$];
  bit quiet = 1'b0;          // no idling in the closing stretch
  int failures = 0;
  int cycle_count = 0;

  // Register settings per phase
  int cfg_w [7] = '{16, 1, 256, 0, 200, 7, 256};
  int cfg_h [7] = '{12, 1, 256, 511, 37, 256, 256};
  int cfg_a [7] = '{32767, -32768, -32768, 100, -1, 12000, 2560};

  // Integer square root, bit pair by bit pair
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint trunc16(longint v);
    if (v >= 0) return v >>> 16;
    return -((-v) >>> 16);
  endfunction

  // Work out which stored pixel the twirl maps output (px, py) onto
  function automatic void twirl_source(input int px, input int py,
                                       output int sx, output int sy);
    longint w, h, dx, dy, ang, mag, theta, c, s, offx, offy, tx, ty;
    longint unsigned d2, dd2, ratio;
    logic [31:0] phase;
    int signed x, y, z, xs, ys;
    w = img_w > FRAME_W ? FRAME_W : img_w;
    h = img_h > FRAME_H ? FRAME_H : img_h;
    if (w < 1) w = 1;
    if (h < 1) h = 1;
    dx = px - w / 2;
    dy = py - h / 2;
    d2 = dx * dx + dy * dy;
    dd2 = w * w + h * h;
    ratio = root64((d2 << 32) / dd2);
    ang = twist;
    mag = ((ang < 0 ? -ang : ang) * longint'(ratio) + 32768) >>> 16;
    theta = ang < 0 ? -mag : mag;
    phase = 32'(theta * longint'(twiw_pkg::RAD_Q8_TO_TURN));
    x = twiw_pkg::CORDIC_START;
    y = 0;
    z = int'({2'b00, phase[29:0]});
    for (int i = 0; i < twiw_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - int'(twiw_pkg::CORDIC_ATAN[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + int'(twiw_pkg::CORDIC_ATAN[i]);
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    offx = trunc16(dx * c - dy * s - dx * 65536);
    offy = trunc16(dx * s + dy * c - dy * 65536);
    tx = px + offx;
    ty = py + offy;
    sx = tx < 0 ? 0 : (tx > w - 1 ? int'(w - 1) : int'(tx));
    sy = ty < 0 ? 0 : (ty > h - 1 ? int'(h - 1) : int'(ty));
  endfunction

  task automatic queue_pixel_write(input int px, input int py, input logic [23:0] rgb);
    twiw_pkg::twiw_src_t wd;
    wd.cmd = twiw_pkg::CMD_WRITE;
    wd.pos_x = 8'(px);
    wd.pos_y = 8'(py);
    {wd.in_red, wd.in_green, wd.in_blue} = rgb;
    frame_pix[py*FRAME_W + px] = rgb;
    pix_written[py*FRAME_W + px] = 1'b1;
    pending_words.push_back(wd);
  endtask

  // Queue a twirled read; write its source first if it was never stored
  task automatic queue_twirl_read(input int px, input int py);
    twiw_pkg::twiw_src_t wd;
    twiw_pkg::twiw_res_t rd;
    int sx, sy;
    twirl_source(px, py, sx, sy);
    if (!pix_written[sy*FRAME_W + sx]) queue_pixel_write(sx, sy, 24'($urandom));
    wd.cmd = twiw_pkg::CMD_READ;
    wd.pos_x = 8'(px);
    wd.pos_y = 8'(py);
    {wd.in_red, wd.in_green, wd.in_blue} = 24'($urandom);
    {rd.out_red, rd.out_green, rd.out_blue} = frame_pix[sy*FRAME_W + sx];
    pending_words.push_back(wd);
    expected_pixels.push_back(rd);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back; valid stays high between them
  task automatic load_registers(input int w, input int h, input int ang);
    logic [twiw_pkg::CFG_DATA_W-1:0] vals [3];
    logic [twiw_pkg::CFG_IDX_W-1:0] idx [3];
    idx[0] = twiw_pkg::CFG_IMAGE_WIDTH;  vals[0] = {7'($urandom), 9'(w)};
    idx[1] = twiw_pkg::CFG_IMAGE_HEIGHT; vals[1] = {7'($urandom), 9'(h)};
    idx[2] = twiw_pkg::CFG_MAX_ANGLE;    vals[2] = 16'(ang);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    img_w = 9'(w);
    img_h = 9'(h);
    twist = 16'(ang);
  endtask

  // Source driver: advance on acceptance, hold a stalled word, idle in bursts
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (src_valid && src_stall) begin
      // hold the word until it is taken
    end else begin
      if (src_valid) void'(pending_words.pop_front());
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        src_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        src_gap <= $urandom_range(0, 9);
        src_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        src_valid <= 1'b1;
        src_word <= pending_words[0];
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Result side: stall in bursts, compare each accepted word with the oldest expectation
  int res_gap = 0;
  always @(posedge clk) begin
    twiw_pkg::twiw_res_t exp_pix;
    if (!rst && res_valid && !res_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result word %h", res_word);
        failures++;
      end else begin
        exp_pix = expected_pixels.pop_front();
        if (res_word.out_red !== exp_pix.out_red) begin
          $error("out_red: expected %h, got %h", exp_pix.out_red, res_word.out_red);
          failures++;
        end
        if (res_word.out_green !== exp_pix.out_green) begin
          $error("out_green: expected %h, got %h", exp_pix.out_green, res_word.out_green);
          failures++;
        end
        if (res_word.out_blue !== exp_pix.out_blue) begin
          $error("out_blue: expected %h, got %h", exp_pix.out_blue, res_word.out_blue);
          failures++;
        end
      end
    end
    if (res_gap > 0) begin
      res_gap <= res_gap - 1;
      res_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 24) == 0) begin
      res_gap <= $urandom_range(0, 9);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** twirl_image_warp_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int aw, ah, x, y;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners and center at the default 256 x 256, extreme colors
    queue_pixel_write(0, 0, 24'hFFFFFF);
    queue_pixel_write(255, 255, 24'h000000);
    queue_pixel_write(128, 128, 24'hA5C35A);
    queue_pixel_write(255, 0, 24'h5A3CA5);
    queue_twirl_read(128, 128);
    queue_twirl_read(0, 0);
    queue_twirl_read(255, 255);
    queue_twirl_read(0, 255);
    queue_twirl_read(255, 0);
    queue_twirl_read(128, 0);
    queue_twirl_read(0, 128);
    queue_pixel_write(128, 128, 24'h123456);
    queue_twirl_read(128, 128);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      load_registers(cfg_w[ph], cfg_h[ph], cfg_a[ph]);
      aw = img_w > FRAME_W ? FRAME_W : (img_w < 1 ? 1 : int'(img_w));
      ah = img_h > FRAME_H ? FRAME_H : (img_h < 1 ? 1 : int'(img_h));
      if (ph == 6) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // keep reads mostly inside the active image, some anywhere in the store
        if ($urandom_range(0, 3) == 0) begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end else begin
          x = $urandom_range(0, aw - 1);
          y = $urandom_range(0, ah - 1);
        end
        if ($urandom_range(0, 9) < 4) queue_pixel_write(x, y, 24'($urandom));
        else queue_twirl_read(x, y);
      end
      wait_drained();
    end

    if (failures == 0) begin
      $display("** twirl_image_warp_core: PASSED **");
    end else begin
      $display("** twirl_image_warp_core: FAILED **");
    end
    $finish;
  end
endmodule
